// ----- rtl/core/pcrm_pkg.sv -----
// pcrm_pkg: shared types and constants of the phase current RMS monitor.
// No dependencies.
package pcrm_pkg;
	localparam int SqW = 32;
	localparam int SumW = 43;
	localparam int CntW = 13;
	localparam int RmsW = 16;
	localparam logic [15:0] OneAmpQ88 = 16'd256;
	localparam logic ActSample = 1'b0;
	localparam logic ActReport = 1'b1;
	localparam logic CfgThreshold = 1'b0;
	localparam logic CfgRetry = 1'b1;

	typedef struct packed {
		logic load;
		logic div_start;
		logic sqrt_start;
		logic push;
		logic sum_clear;
		logic sum_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic sum_last;
	} sts_t;
endpackage

// ----- rtl/core/pcrm_if.sv -----
// pcrm_if: valid/ready channel interfaces for input, result and configuration.
// No dependencies.
interface pcrm_in_if;
	logic valid;
	logic ready;
	logic action;
	logic signed [15:0] current_a;
	logic signed [15:0] current_b;
	logic signed [15:0] current_c;
	logic [31:0] now_ms;
	modport source(output valid, action, current_a, current_b, current_c, now_ms,
		input ready);
	modport sink(input valid, action, current_a, current_b, current_c, now_ms,
		output ready);
endinterface

interface pcrm_out_if;
	logic valid;
	logic ready;
	logic [15:0] rms_a;
	logic [15:0] rms_b;
	logic [15:0] rms_c;
	logic [15:0] peak_rms;
	logic overcurrent_tripped;
	logic in_cooldown;
	logic samples_dropped;
	logic [12:0] sample_count;
	modport source(output valid, rms_a, rms_b, rms_c, peak_rms, overcurrent_tripped,
		in_cooldown, samples_dropped, sample_count, input ready);
	modport sink(input valid, rms_a, rms_b, rms_c, peak_rms, overcurrent_tripped,
		in_cooldown, samples_dropped, sample_count, output ready);
endinterface

interface pcrm_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/phase_current_rms_overcurrent_monitor.sv -----
// Phase current RMS monitor with windowed overcurrent trip; top level.
// Depends on pcrm_pkg, pcrm_if, pcrm_ctrl and pcrm_dp.
//
// A sample item (action 0) does not run the sequencer; the block can accept one
// sample per clock while idle, squares go through a two-stage multiply and
// add into 43-bit per-phase accumulators. A report item (action 1) runs the
// sequencer: a restoring divide of the three sums by the count, a load of
// the root, a bitwise square root, a push into the peak window, a sequential
// clipped sum over the window entries, and the trip and cooldown update,
// after which the result is valid. The result is held in an output register
// until taken; the next item is accepted while a result waits, except a
// report which waits for the output register to drain. A report is also held
// off after the last accepted sample until that sample's squares reach the
// accumulators. The peak window resets to zero.
module phase_current_rms_overcurrent_monitor #(
	parameter int WINDOW_DEPTH = 10,
	parameter int MAX_SAMPLES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	pcrm_in_if.sink in_ch,
	pcrm_out_if.source out_ch,
	pcrm_cfg_if.sink cfg
);
	logic [15:0] thresh_q;
	logic [31:0] retry_q;
	pcrm_pkg::cmd_t cmd;
	pcrm_pkg::sts_t sts;
	logic busy, out_v_q, acc, sample_go, report_go, acc_busy;
	logic [15:0] ra, rb, rc, pk;
	logic trip, cool, drop;
	logic [12:0] cnt;

	// configuration: always ready, write by index
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 16'd12800;
			retry_q <= 32'd1000;
		end else if (cfg.valid) begin
			case (cfg.index)
				pcrm_pkg::CfgThreshold: thresh_q <= cfg.data[15:0];
				pcrm_pkg::CfgRetry: retry_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// hold off reports until the previous result is gone and the sums are complete
	assign in_ch.ready = !busy &&
		!(in_ch.action == pcrm_pkg::ActReport && (out_v_q || acc_busy));
	assign acc = in_ch.valid && in_ch.ready;
	assign sample_go = acc && (in_ch.action == pcrm_pkg::ActSample);
	assign report_go = acc && (in_ch.action == pcrm_pkg::ActReport);

	pcrm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .report_go(report_go), .sts(sts),
		.cmd(cmd), .busy(busy)
	);

	pcrm_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk(clk), .arst_n(arst_n), .sample_go(sample_go),
		.cur_a(in_ch.current_a), .cur_b(in_ch.current_b), .cur_c(in_ch.current_c),
		.now_in(in_ch.now_ms), .thresh(thresh_q), .retry(retry_q),
		.cmd(cmd), .sts(sts), .acc_busy(acc_busy),
		.rms_a(ra), .rms_b(rb), .rms_c(rc), .peak(pk),
		.tripped(trip), .cool(cool), .dropped(drop), .count(cnt)
	);

	// raise valid after the final sequencer step; drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (cmd.finish) out_v_q <= 1'b1;
		else if (out_ch.ready) out_v_q <= 1'b0;
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.rms_a = ra;
	assign out_ch.rms_b = rb;
	assign out_ch.rms_c = rc;
	assign out_ch.peak_rms = pk;
	assign out_ch.overcurrent_tripped = trip;
	assign out_ch.in_cooldown = cool;
	assign out_ch.samples_dropped = drop;
	assign out_ch.sample_count = cnt;
endmodule

// ----- rtl/core/pcrm_ctrl.sv -----
// pcrm_ctrl: report sequencer (divide, square root, window push, window sum).
// Depends on pcrm_pkg.
module pcrm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic report_go,
	input  pcrm_pkg::sts_t sts,
	output pcrm_pkg::cmd_t cmd,
	output logic busy
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV = 3'd1;
	localparam logic [2:0] S_SQRT = 3'd2;
	localparam logic [2:0] S_PUSH = 3'd3;
	localparam logic [2:0] S_SUM = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;
	localparam logic [2:0] S_ROOT = 3'd6;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: if (report_go) begin
				cmd.load = 1'b1;
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			// pass through S_ROOT so the last quotient bit is in place before the root starts
			S_DIV: if (sts.div_done) state_d = S_ROOT;
			S_ROOT: begin
				cmd.sqrt_start = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: if (sts.sqrt_done) state_d = S_PUSH;
			S_PUSH: begin
				cmd.push = 1'b1;
				cmd.sum_clear = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ----- rtl/core/pcrm_dp.sv -----
// pcrm_dp: accumulators, shared divider and square root, peak window, trip logic.
// Depends on pcrm_pkg.
module pcrm_dp #(
	parameter int WINDOW_DEPTH = 10,
	parameter int MAX_SAMPLES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_go,
	input  logic signed [15:0] cur_a,
	input  logic signed [15:0] cur_b,
	input  logic signed [15:0] cur_c,
	input  logic [31:0] now_in,
	input  logic [15:0] thresh,
	input  logic [31:0] retry,
	input  pcrm_pkg::cmd_t cmd,
	output pcrm_pkg::sts_t sts,
	output logic acc_busy,
	output logic [15:0] rms_a,
	output logic [15:0] rms_b,
	output logic [15:0] rms_c,
	output logic [15:0] peak,
	output logic tripped,
	output logic cool,
	output logic dropped,
	output logic [12:0] count
);
	localparam int PosW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CntFullW = $clog2(MAX_SAMPLES + 1);
	localparam int SumW = pcrm_pkg::SumW;

	// sample squaring, registered, then added
	logic [15:0] mag_a_s1, mag_b_s1, mag_c_s1;
	logic sq_v_s1, sq_v_s2;
	logic [31:0] sq_a_s2, sq_b_s2, sq_c_s2;
	logic [SumW-1:0] acc_q [3];
	logic [CntFullW-1:0] cnt_q;
	logic drop_q;

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	always_ff @(posedge clk) begin
		mag_a_s1 <= mag16(cur_a);
		mag_b_s1 <= mag16(cur_b);
		mag_c_s1 <= mag16(cur_c);
		sq_a_s2 <= mag_a_s1 * mag_a_s1;
		sq_b_s2 <= mag_b_s1 * mag_b_s1;
		sq_c_s2 <= mag_c_s1 * mag_c_s1;
	end

	// count is advanced at acceptance so saturation sees every earlier sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
			cnt_q <= '0;
			drop_q <= 1'b0;
			for (int i = 0; i < 3; i++) acc_q[i] <= '0;
		end else begin
			sq_v_s1 <= 1'b0;
			sq_v_s2 <= sq_v_s1;
			if (cmd.load) begin
				cnt_q <= '0;
				drop_q <= 1'b0;
				for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			end else begin
				if (sample_go) begin
					if (cnt_q >= CntFullW'(MAX_SAMPLES)) drop_q <= 1'b1;
					else begin
						cnt_q <= cnt_q + 1'b1;
						sq_v_s1 <= 1'b1;
					end
				end
				if (sq_v_s2) begin
					acc_q[0] <= acc_q[0] + SumW'(sq_a_s2);
					acc_q[1] <= acc_q[1] + SumW'(sq_b_s2);
					acc_q[2] <= acc_q[2] + SumW'(sq_c_s2);
				end
			end
		end
	end

	// squares still on their way to the accumulators
	assign acc_busy = sq_v_s1 | sq_v_s2;

	// report snapshot
	logic [SumW-1:0] snap_q [3];
	logic [CntFullW-1:0] div_q;
	logic [31:0] now_q;

	// shared restoring divider, three phases in parallel, one bit a cycle
	logic [SumW-1:0] quo_q [3];
	logic [CntFullW:0] rem_q [3];
	logic [5:0] dbit_q;
	logic div_run_q;

	// bitwise square root, three lanes, one result bit a cycle
	logic [SumW-1:0] sx_q [3];
	logic [SumW:0] root_q [3];
	logic [SumW:0] sbit_q;
	logic sqrt_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			sqrt_run_q <= 1'b0;
			dbit_q <= '0;
			sbit_q <= '0;
		end else begin
			if (cmd.div_start) begin
				div_run_q <= 1'b1;
				dbit_q <= 6'(SumW - 1);
			end else if (div_run_q) begin
				if (dbit_q == 6'd0) div_run_q <= 1'b0;
				else dbit_q <= dbit_q - 1'b1;
			end
			if (cmd.sqrt_start) begin
				sqrt_run_q <= 1'b1;
				sbit_q <= (SumW+1)'(1) << 42;
			end else if (sqrt_run_q) begin
				sbit_q <= sbit_q >> 2;
				if (sbit_q[0] || sbit_q[1]) sqrt_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) snap_q[i] <= acc_q[i];
			div_q <= (cnt_q == '0) ? CntFullW'(1) : cnt_q;
			count <= 13'(cnt_q);
			dropped <= drop_q | (sample_go & (cnt_q >= CntFullW'(MAX_SAMPLES)));
			now_q <= now_in;
		end
		if (cmd.div_start) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (div_run_q) begin
			for (int i = 0; i < 3; i++) begin
				logic [CntFullW+1:0] t;
				t = {rem_q[i], snap_q[i][dbit_q]};
				if (t >= (CntFullW+2)'(div_q)) begin
					rem_q[i] <= (CntFullW+1)'(t - (CntFullW+2)'(div_q));
					quo_q[i][dbit_q] <= 1'b1;
				end else begin
					rem_q[i] <= (CntFullW+1)'(t);
				end
			end
		end
		if (cmd.sqrt_start) begin
			for (int i = 0; i < 3; i++) begin
				sx_q[i] <= quo_q[i];
				root_q[i] <= '0;
			end
		end else if (sqrt_run_q) begin
			for (int i = 0; i < 3; i++) begin
				logic [SumW+1:0] trial;
				trial = {1'b0, root_q[i]} + {1'b0, sbit_q};
				if ({2'b0, sx_q[i]} >= trial) begin
					sx_q[i] <= SumW'({2'b0, sx_q[i]} - trial);
					root_q[i] <= (root_q[i] >> 1) + sbit_q;
				end else begin
					root_q[i] <= root_q[i] >> 1;
				end
			end
		end
	end

	assign sts.div_done = div_run_q && (dbit_q == 6'd0);
	assign sts.sqrt_done = sqrt_run_q && (sbit_q[0] || sbit_q[1]);

	// peak of the three roots
	logic [15:0] ra, rb, rc, pk;
	assign ra = root_q[0][15:0];
	assign rb = root_q[1][15:0];
	assign rc = root_q[2][15:0];
	always_comb begin
		pk = ra;
		if (rb > pk) pk = rb;
		if (rc > pk) pk = rc;
	end

	// window of peaks and its sequential sum
	logic [15:0] win_q [WINDOW_DEPTH];
	logic [PosW-1:0] pos_q, sidx_q;
	logic [31:0] total_q;
	logic cool_q;
	logic [31:0] start_q;
	logic [15:0] ent;

	assign ent = (win_q[sidx_q] > thresh) ? thresh : win_q[sidx_q];
	assign sts.sum_last = (sidx_q == PosW'(WINDOW_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) win_q[i] <= '0;
			pos_q <= '0;
			sidx_q <= '0;
			cool_q <= 1'b0;
			start_q <= '0;
		end else begin
			if (cmd.push) begin
				win_q[pos_q] <= pk;
				pos_q <= (pos_q == PosW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
				sidx_q <= '0;
			end
			if (cmd.sum_step && !sts.sum_last) sidx_q <= sidx_q + 1'b1;
			if (cmd.finish) begin
				logic trip, c;
				logic [31:0] st;
				trip = (total_q > 32'(thresh) * 32'(WINDOW_DEPTH)) && !cool_q;
				c = cool_q | trip;
				st = trip ? now_q : start_q;
				if (c && (now_q > st + retry)) begin
					c = 1'b0;
					st = now_q;
				end
				cool_q <= c;
				start_q <= st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_clear) total_q <= '0;
		else if (cmd.sum_step) total_q <= total_q + 32'(ent) + 32'(pcrm_pkg::OneAmpQ88);
		if (cmd.push) begin
			rms_a <= ra;
			rms_b <= rb;
			rms_c <= rc;
			peak <= pk;
		end
		if (cmd.finish) begin
			tripped <= (total_q > 32'(thresh) * 32'(WINDOW_DEPTH)) && !cool_q;
		end
	end

	assign cool = cool_q;
endmodule

// ----- tb/sv/tb_phase_current_rms_overcurrent_monitor.sv -----
// Testbench for phase_current_rms_overcurrent_monitor: directed and random
// sample/report items under varied idling, checked against an in-bench predictor.
// Depends on pcrm_pkg, pcrm_if and the monitor RTL.
module tb_phase_current_rms_overcurrent_monitor;
	localparam int WinDepth = 10;
	localparam int MaxSamples = 4096;
	localparam int DrainCycles = 150;   // margin for a report that is still running
	localparam int StallLimit = 6000;   // cycles with no handshake at all
	localparam int HoldCycles = 400;    // long receiver hold-off

	typedef struct {
		logic action;
		logic signed [15:0] cur_a;
		logic signed [15:0] cur_b;
		logic signed [15:0] cur_c;
		logic [31:0] now;
	} phase_item_t;

	typedef struct packed {
		logic [15:0] rms_a;
		logic [15:0] rms_b;
		logic [15:0] rms_c;
		logic [15:0] peak;
		logic tripped;
		logic cooling;
		logic dropped;
		logic [12:0] count;
	} rms_report_t;

	// Predicts each report from the accumulated samples and checks arrivals.
	class rms_trip_predictor;
		logic [15:0] threshold;
		logic [31:0] retry;
		longint unsigned acc[3];
		int unsigned n_samples;
		bit dropped;
		logic [15:0] window[WinDepth];
		int unsigned wpos;
		bit cooling;
		logic [31:0] cool_start;
		rms_report_t due[$];
		int unsigned mismatches;
		int unsigned reports;
		int unsigned trips;
		int unsigned drop_reports;

		function new();
			threshold = 16'd12800;
			retry = 32'd1000;
			foreach (acc[i]) acc[i] = 0;
			n_samples = 0;
			dropped = 0;
			foreach (window[i]) window[i] = '0;
			wpos = 0;
			cooling = 0;
			cool_start = '0;
			mismatches = 0;
			reports = 0;
			trips = 0;
			drop_reports = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] d);
			if (idx == pcrm_pkg::CfgThreshold)
				threshold = d[15:0];
			else
				retry = d;
		endfunction

		function longint unsigned square(logic signed [15:0] v);
			longint m;
			m = v;
			if (m < 0)
				m = -m;
			return longint'(m * m);
		endfunction

		function logic [15:0] root_floor(longint unsigned x);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r[15:0];
		endfunction

		function void take_item(phase_item_t it);
			rms_report_t r;
			int unsigned div;
			int unsigned total;
			int unsigned lim;
			logic [31:0] deadline;
			logic [15:0] e;
			if (it.action == pcrm_pkg::ActSample) begin
				if (n_samples >= MaxSamples) begin
					dropped = 1;
				end else begin
					acc[0] += square(it.cur_a);
					acc[1] += square(it.cur_b);
					acc[2] += square(it.cur_c);
					n_samples++;
				end
				return;
			end
			div = (n_samples == 0) ? 1 : n_samples;
			r.rms_a = root_floor(acc[0] / div);
			r.rms_b = root_floor(acc[1] / div);
			r.rms_c = root_floor(acc[2] / div);
			r.peak = r.rms_a;
			if (r.rms_b > r.peak)
				r.peak = r.rms_b;
			if (r.rms_c > r.peak)
				r.peak = r.rms_c;
			window[wpos] = r.peak;
			wpos = (wpos + 1) % WinDepth;
			total = 0;
			foreach (window[i]) begin
				e = (window[i] > threshold) ? threshold : window[i];
				total += e + pcrm_pkg::OneAmpQ88;
			end
			lim = threshold * WinDepth;
			r.tripped = 0;
			if (total > lim && !cooling) begin
				cooling = 1;
				cool_start = it.now;
				r.tripped = 1;
				trips++;
			end
			if (cooling) begin
				deadline = cool_start + retry;
				if (it.now > deadline) begin
					cooling = 0;
					cool_start = it.now;
				end
			end
			r.cooling = cooling;
			r.dropped = dropped;
			r.count = n_samples[12:0];
			if (dropped)
				drop_reports++;
			due.push_back(r);
			foreach (acc[i]) acc[i] = 0;
			n_samples = 0;
			dropped = 0;
		endfunction

		function void check_report(rms_report_t got);
			rms_report_t exp_r;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report %p", got);
				return;
			end
			exp_r = due.pop_front();
			reports++;
			if (got.rms_a !== exp_r.rms_a || got.rms_b !== exp_r.rms_b ||
					got.rms_c !== exp_r.rms_c || got.peak !== exp_r.peak ||
					got.tripped !== exp_r.tripped || got.cooling !== exp_r.cooling ||
					got.dropped !== exp_r.dropped || got.count !== exp_r.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %0d mismatch: expected %p got %p", reports, exp_r, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pcrm_in_if in_ch();
	pcrm_out_if out_ch();
	pcrm_cfg_if cfg();

	phase_current_rms_overcurrent_monitor #(
		.WINDOW_DEPTH(WinDepth),
		.MAX_SAMPLES(MaxSamples)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	rms_trip_predictor model = new();

	int send_gap_pct;     // chance per cycle that the sender idles
	int recv_stall_pct;   // chance per cycle that the receiver stalls
	int hold_len;         // set by the main flow, picked up by the receiver
	int hold_cnt;
	int items_sent;
	int idle_cycles;
	logic [31:0] now_clk; // running time base for report items

	// Free-running clock, period 4.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Receiver: decide ready at the falling edge; a pending hold-off wins.
	always @(negedge clk) begin
		if (hold_len != 0) begin
			hold_cnt = hold_len;
			hold_len = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every report taken at the rising edge.
	always @(posedge clk) begin
		rms_report_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.rms_a = out_ch.rms_a;
			got.rms_b = out_ch.rms_b;
			got.rms_c = out_ch.rms_c;
			got.peak = out_ch.peak_rms;
			got.tripped = out_ch.overcurrent_tripped;
			got.cooling = out_ch.in_cooldown;
			got.dropped = out_ch.samples_dropped;
			got.count = out_ch.sample_count;
			model.check_report(got);
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("timeout: no handshake for %0d cycles", StallLimit);
			$display("** phase_current_rms_overcurrent_monitor: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one item; idle first at random, then hold it until taken.
	task automatic send_item(phase_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= it.action;
		in_ch.current_a <= it.cur_a;
		in_ch.current_b <= it.cur_b;
		in_ch.current_c <= it.cur_c;
		in_ch.now_ms <= it.now;
		do @(posedge clk); while (!in_ch.ready);
		model.take_item(it);
		items_sent++;
	endtask

	// Drop valid once the stimulus pauses.
	task automatic release_input();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic sample(logic signed [15:0] a, logic signed [15:0] b,
			logic signed [15:0] c);
		phase_item_t it;
		it.action = pcrm_pkg::ActSample;
		it.cur_a = a;
		it.cur_b = b;
		it.cur_c = c;
		it.now = $urandom;
		send_item(it);
	endtask

	task automatic report(logic [31:0] t);
		phase_item_t it;
		it.action = pcrm_pkg::ActReport;
		it.cur_a = 16'($urandom);
		it.cur_b = 16'($urandom);
		it.cur_c = 16'($urandom);
		it.now = t;
		send_item(it);
	endtask

	// Wait for all reports, then let a report that may still run finish.
	task automatic settle();
		while (model.due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		model.write_reg(idx, d);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_regs(logic [15:0] th, logic [31:0] rt);
		settle();
		write_reg(pcrm_pkg::CfgThreshold, {16'd0, th});
		write_reg(pcrm_pkg::CfgRetry, rt);
	endtask

	// Random current: mostly full range, sometimes extreme or hot magnitudes.
	function automatic logic signed [15:0] rand_current(bit hot);
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return 16'sh8000;
		if (pick == 1)
			return 16'sh7FFF;
		if (hot)
			return ($urandom_range(1)) ? 16'($urandom_range(32767, 12000))
				: -16'($urandom_range(32767, 12000));
		return 16'($urandom);
	endfunction

	// Random part: mostly sample runs closed by a report, plus stray items.
	task automatic random_traffic(int n_items);
		int stop_at;
		int run_len;
		bit hot;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 10) begin
				// noise: lone report, possibly an empty interval, or odd time jump
				now_clk = ($urandom_range(3) == 0) ? $urandom : now_clk + $urandom_range(50);
				report(now_clk);
			end else begin
				run_len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(1, 8);
				hot = 1'($urandom_range(1));
				repeat (run_len)
					sample(rand_current(hot), rand_current(hot), rand_current(hot));
				now_clk += $urandom_range(700);
				report(now_clk);
			end
		end
		release_input();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = pcrm_pkg::ActSample;
		in_ch.current_a = '0;
		in_ch.current_b = '0;
		in_ch.current_c = '0;
		in_ch.now_ms = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = pcrm_pkg::CfgThreshold;
		cfg.data = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_len = 0;
		hold_cnt = 0;
		items_sent = 0;
		idle_cycles = 0;
		now_clk = 32'd100;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty interval, then field extremes at reset settings.
		report(32'd0);
		sample(16'sh8000, 16'sh7FFF, 16'sh0000);
		sample(-16'sd1, 16'sh00FF, 16'sh8000);
		sample(16'sh5555, -16'sh5556, 16'sh0001);
		report(32'hFFFF_FFFF);
		release_input();

		// Threshold zero trips at once; a wrapping deadline expires the same report.
		set_regs(16'd0, 32'h0000_0200);
		report(32'hFFFF_FF00);
		report(32'hFFFF_FF01);
		release_input();

		// Cooldown held, then expired once now passes start plus retry.
		set_regs(16'd0, 32'd1000);
		report(32'd5);
		report(32'd500);
		report(32'd1005);
		report(32'd1006);
		report(32'd1007);
		release_input();

		// Random phases over several register settings and idling patterns.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_regs(16'd12800, 32'd1000);
				1: set_regs(16'd0, 32'd0);
				2: set_regs(16'hFFFF, 32'hFFFF_FFFF);
				3: set_regs(16'd9000, 32'd300);
				default: set_regs(16'($urandom), $urandom_range(2000));
			endcase
			case (ph % 4)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 77;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 77;
				end
				default: begin
					send_gap_pct = 25;
					recv_stall_pct = 25;
				end
			endcase
			// Hold the receiver off for a long stretch while items keep coming.
			if (ph == 3)
				hold_len = HoldCycles;
			random_traffic(260);
		end

		settle();
		$display("run covered %0d items and %0d reports under 5 register settings",
			items_sent, model.reports);
		$display("overcurrent trips %0d, reports with dropped samples %0d",
			model.trips, model.drop_reports);
		if (model.mismatches == 0 && model.due.size() == 0) begin
			$display("** phase_current_rms_overcurrent_monitor: PASSED **");
		end else begin
			$display("mismatches %0d, reports still missing %0d",
				model.mismatches, model.due.size());
			$display("** phase_current_rms_overcurrent_monitor: FAILED **");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/pcrm_pkg.sv
rtl/core/pcrm_if.sv
rtl/core/pcrm_ctrl.sv
rtl/core/pcrm_dp.sv
rtl/core/phase_current_rms_overcurrent_monitor.sv
tb/sv/tb_phase_current_rms_overcurrent_monitor.sv
